// File: rtl/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/bwm_pkg.sv
package bwm_pkg;

  // Defaults for the top-level parameters
  localparam int BMP_COLS_DEF = 1024;
  localparam int BMP_ROWS_DEF = 512;
  localparam int MAX_WIN_DEF  = 8;

  // Bitmap store
  localparam int STORE_DEPTH  = 65536;
  localparam int STORE_ADDR_W = 16;
  localparam int BYTE_W       = 8;

  // Query fields
  localparam int X_W     = 10;
  localparam int Y_W     = 9;
  localparam int Y_RANGE = 512;
  localparam int X_RANGE = 1024;

  // Result fields
  localparam int COUNT_W = 7;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

  // Item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Configuration registers
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int WIN_W      = 4;
  localparam int THR_W      = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd2;
  localparam logic [WIN_W-1:0] WIN_WIDTH_RST  = 4'd6;
  localparam logic [WIN_W-1:0] WIN_HEIGHT_RST = 4'd3;
  localparam logic [THR_W-1:0] THRESHOLD_RST  = 7'd6;

  // Query sequencer
  typedef enum logic [1:0] {
    BWM_IDLE,
    BWM_SCAN,
    BWM_DRAIN,
    BWM_FINISH
  } bwm_state_t;

endpackage

// File: rtl/bwm_in_if.sv
interface bwm_in_if;
  import bwm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic [STORE_ADDR_W-1:0] byte_addr;
  logic [BYTE_W-1:0]       byte_data;
  logic [X_W-1:0]          x_pos;
  logic [Y_W-1:0]          y_pos;

  modport source (output valid, kind, byte_addr, byte_data, x_pos, y_pos, input ready);
  modport sink (input valid, kind, byte_addr, byte_data, x_pos, y_pos, output ready);
endinterface

// File: rtl/bwm_out_if.sv
interface bwm_out_if;
  import bwm_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] black_count;
  logic               mostly_black;

  modport source (output valid, black_count, mostly_black, input ready);
  modport sink (input valid, black_count, mostly_black, output ready);
endinterface

// File: rtl/bwm_ram.sv
module bwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/bitmap_window_majority.sv
// Box-majority counter over a one-bit-per-pixel bitmap held in a 64 KiB
// byte RAM (XBM layout: rows padded to whole bytes, leftmost pixel in bit 0).
// A load beat writes one byte. A query beat reads the window row by row, NB
// bytes per row (NB = 2 for MAX_WIN = 8), one RAM read per cycle through the
// single read port; a window of zero height reads nothing. The finished count
// sits in an output register, so the next beat is taken while a result still
// waits; a further query holds in its last step until that register frees up.
`include "assert_macros.svh"

module bitmap_window_majority #(
  parameter int BMP_COLS = bwm_pkg::BMP_COLS_DEF,
  parameter int BMP_ROWS = bwm_pkg::BMP_ROWS_DEF,
  parameter int MAX_WIN  = bwm_pkg::MAX_WIN_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  bwm_in_if.sink                          in_bus,
  bwm_out_if.source                       out_bus,
  input  logic                            cfg_we,
  input  logic [bwm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bwm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import bwm_pkg::*;

  localparam int ROW_STRIDE = (BMP_COLS + 7) / 8;
  localparam int NB         = (MAX_WIN + 14) / 8;
  localparam int K_W        = $clog2(NB + 1);
  localparam int R_W        = $clog2(MAX_WIN + 1);
  localparam int S_W        = K_W + 4;
  localparam int PY_W       = $clog2(Y_RANGE + MAX_WIN);
  localparam int BC_W       = $clog2(X_RANGE / 8 + NB + 1);
  localparam int RS_W       = $clog2(ROW_STRIDE + 1);
  localparam int PX_IMG_W   = $clog2(BMP_COLS + 1);
  localparam int PX_W       = (BC_W + 3 > PX_IMG_W) ? BC_W + 3 : PX_IMG_W;
  localparam int PY_IMG_W   = $clog2(BMP_ROWS + 1);
  localparam int PYC_W      = (PY_W > PY_IMG_W) ? PY_W : PY_IMG_W;
  localparam int FA_W       = PY_W + RS_W + BC_W;

  // Configuration registers
  logic [WIN_W-1:0] win_width_r;
  logic [WIN_W-1:0] win_height_r;
  logic [THR_W-1:0] threshold_r;

  // Sequencer and datapath registers
  bwm_state_t         state_r, state_nxt;
  logic [X_W-1:0]     cx_r;
  logic [Y_W-1:0]     cy_r;
  logic [R_W-1:0]     row_r;
  logic [K_W-1:0]     byte_r;
  logic [COUNT_W-1:0] count_r;
  logic               dv_r;
  logic [BYTE_W-1:0]  mask_r;
  logic               out_valid_r;
  logic [COUNT_W-1:0] out_count_r;
  logic               out_mostly_r;

  // Combinational signals
  logic               in_ready;
  logic               rd_en;
  logic               in_fire;
  logic               load_fire;
  logic               query_fire;
  logic               out_free;
  logic [R_W-1:0]     w_cl;
  logic [R_W-1:0]     h_cl;
  logic               last_byte;
  logic               last_row;
  logic [PY_W-1:0]    py;
  logic [BC_W-1:0]    bc;
  logic [FA_W-1:0]    full_addr;
  logic               row_ok;
  logic               addr_ok;
  logic [BYTE_W-1:0]  mask_nxt;
  logic [BYTE_W-1:0]  rd_data;
  logic [3:0]         pop;
  logic [COUNT_W:0]   acc;
  logic [COUNT_W-1:0] acc_sat;

  assign in_fire    = in_bus.valid && in_ready;
  assign load_fire  = in_fire && (in_bus.kind == KIND_LOAD);
  assign query_fire = in_fire && (in_bus.kind == KIND_QUERY);
  assign out_free   = !out_valid_r || out_bus.ready;

  // Clamp window size to MAX_WIN
  assign w_cl = ({1'b0, win_width_r} > (WIN_W + 1)'(MAX_WIN)) ? R_W'(MAX_WIN)
                                                                : R_W'(win_width_r);
  assign h_cl = ({1'b0, win_height_r} > (WIN_W + 1)'(MAX_WIN)) ? R_W'(MAX_WIN)
                                                                 : R_W'(win_height_r);

  // Write configuration registers; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_width_r  <= WIN_WIDTH_RST;
      win_height_r <= WIN_HEIGHT_RST;
      threshold_r  <= THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIN_WIDTH:  win_width_r  <= cfg_wdata[WIN_W-1:0];
        CFG_WIN_HEIGHT: win_height_r <= cfg_wdata[WIN_W-1:0];
        CFG_THRESHOLD:  threshold_r  <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Position of the byte being read this cycle
  assign last_byte = (byte_r == K_W'(NB - 1));
  assign last_row  = (row_r == h_cl - R_W'(1));
  assign py        = PY_W'(cy_r) + PY_W'(row_r);
  assign bc        = BC_W'(cx_r[X_W-1:3]) + BC_W'(byte_r);
  assign full_addr = FA_W'(py) * FA_W'(ROW_STRIDE) + FA_W'(bc);
  assign row_ok    = (PYC_W'(py) < PYC_W'(BMP_ROWS));
  assign addr_ok   = (full_addr < FA_W'(STORE_DEPTH));

  // Build the pixel mask for this byte
  always_comb begin
    logic [S_W-1:0]  s;
    logic [S_W-1:0]  off;
    logic [PX_W-1:0] px;
    mask_nxt = '0;
    off      = S_W'(cx_r[2:0]);
    for (int b = 0; b < BYTE_W; b++) begin
      s  = S_W'({byte_r, 3'(b)});
      px = PX_W'({bc, 3'(b)});
      mask_nxt[b] = (s >= off) && ((s - off) < S_W'(w_cl))
                    && (px < PX_W'(BMP_COLS)) && row_ok && addr_ok;
    end
  end

  // Bitmap memory
  bwm_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (load_fire),
    .wr_addr (in_bus.byte_addr),
    .wr_data (in_bus.byte_data),
    .rd_en   (rd_en),
    .rd_addr (full_addr[STORE_ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  // Count set pixels of the returned byte and saturate
  always_comb begin
    pop = '0;
    for (int b = 0; b < BYTE_W; b++) begin
      pop = pop + 4'(rd_data[b] & mask_r[b]);
    end
    acc     = {1'b0, count_r} + (COUNT_W + 1)'(pop);
    acc_sat = acc[COUNT_W] ? COUNT_MAX : acc[COUNT_W-1:0];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BWM_IDLE: begin
        if (query_fire) begin
          state_nxt = (h_cl == '0) ? BWM_FINISH : BWM_SCAN;
        end
      end
      BWM_SCAN: begin
        if (last_byte && last_row) begin
          state_nxt = BWM_DRAIN;
        end
      end
      BWM_DRAIN: state_nxt = BWM_FINISH;
      BWM_FINISH: begin
        if (out_free) begin
          state_nxt = BWM_IDLE;
        end
      end
      default: state_nxt = BWM_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    case (state_r)
      BWM_IDLE: in_ready = 1'b1;
      BWM_SCAN: rd_en    = 1'b1;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BWM_IDLE;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dv_r    <= rd_en;
      if (state_r == BWM_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers: latch corner, walk rows and bytes, accumulate
  always_ff @(posedge clk) begin
    mask_r <= mask_nxt;
    if (query_fire) begin
      cx_r    <= in_bus.x_pos;
      cy_r    <= in_bus.y_pos;
      row_r   <= '0;
      byte_r  <= '0;
      count_r <= '0;
    end else begin
      if (rd_en) begin
        if (last_byte) begin
          byte_r <= '0;
          row_r  <= row_r + R_W'(1);
        end else begin
          byte_r <= byte_r + K_W'(1);
        end
      end
      if (dv_r) begin
        count_r <= acc_sat;
      end
    end
    if (state_r == BWM_FINISH && out_free) begin
      out_count_r  <= count_r;
      out_mostly_r <= (count_r >= threshold_r);
    end
  end

  assign in_bus.ready         = in_ready;
  assign out_bus.valid        = out_valid_r;
  assign out_bus.black_count  = out_count_r;
  assign out_bus.mostly_black = out_mostly_r;

  // Read data only returns while a scan is in flight
  `ASSERT_IMPLIES(a_dv_in_scan, clk, rst_n, dv_r, (state_r == BWM_SCAN) || (state_r == BWM_DRAIN))
  // No read is outstanding once the count is final
  `ASSERT_IMPLIES(a_finish_drained, clk, rst_n, state_r == BWM_FINISH, !dv_r)
  // A query with rows starts scanning next cycle
  `ASSERT_NEXT(a_query_scans, clk, rst_n, query_fire && (h_cl != '0), state_r == BWM_SCAN)
  // Flag agrees with the held count
  `ASSERT_IMPLIES(a_flag_matches, clk, rst_n, out_valid_r, out_mostly_r == (out_count_r >= threshold_r))

endmodule

// File: tb/bitmap_window_majority_tb.sv
module bitmap_window_majority_tb;
  import bwm_pkg::*;

  localparam int ROW_BYTES   = (BMP_COLS_DEF + 7) / 8;
  localparam int SETTLE_CYC  = 40;
  localparam int HOLDOFF_CYC = 300;

  typedef struct packed {
    logic                    kind;
    logic [STORE_ADDR_W-1:0] byte_addr;
    logic [BYTE_W-1:0]       byte_data;
    logic [X_W-1:0]          x_pos;
    logic [Y_W-1:0]          y_pos;
  } pixel_beat_t;

  typedef struct packed {
    logic [COUNT_W-1:0] black_count;
    logic               mostly_black;
  } window_tally_t;

  typedef enum logic [1:0] {
    PACE_NONE,
    PACE_SENDER,
    PACE_SINK,
    PACE_BOTH
  } pacing_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  bwm_in_if  in_bus ();
  bwm_out_if out_bus ();

  bitmap_window_majority DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow of the bitmap and the window registers
  bit   [BYTE_W-1:0] shadow_bitmap [0:STORE_DEPTH-1];
  logic [WIN_W-1:0]  win_width_cfg  = WIN_WIDTH_RST;
  logic [WIN_W-1:0]  win_height_cfg = WIN_HEIGHT_RST;
  logic [THR_W-1:0]  threshold_cfg  = THRESHOLD_RST;

  // Bytes the stimulus has already loaded, so queries never touch unwritten ones
  bit loaded_bytes [0:STORE_DEPTH-1];

  pixel_beat_t   beats_to_send [$];
  window_tally_t tallies_due [$];
  int            items_queued     = 0;
  int            mismatch_count   = 0;
  int unsigned   sender_idle_pct  = 0;
  int unsigned   sink_stall_pct   = 0;
  int            holdoff_requests = 0;
  int            holdoff_served   = 0;
  int            holdoff_left     = 0;

  // Count set pixels in the current window from corner (cx, cy)
  function automatic window_tally_t window_tally(input logic [X_W-1:0] cx,
                                                 input logic [Y_W-1:0] cy);
    int unsigned   w, h, cnt, px, py, addr, i, j;
    window_tally_t t;
    w   = (win_width_cfg > MAX_WIN_DEF) ? MAX_WIN_DEF : win_width_cfg;
    h   = (win_height_cfg > MAX_WIN_DEF) ? MAX_WIN_DEF : win_height_cfg;
    cnt = 0;
    for (j = 0; j < h; j++) begin
      for (i = 0; i < w; i++) begin
        px = cx + i;
        py = cy + j;
        if (px < BMP_COLS_DEF && py < BMP_ROWS_DEF) begin
          addr = py * ROW_BYTES + (px >> 3);
          if (addr < STORE_DEPTH) cnt += shadow_bitmap[addr][px % 8];
        end
      end
    end
    if (cnt > COUNT_MAX) cnt = COUNT_MAX;
    t.black_count  = COUNT_W'(cnt);
    t.mostly_black = (cnt >= threshold_cfg);
    return t;
  endfunction

  // Clock and known input values from time zero
  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_WIN_WIDTH;
    cfg_wdata        = '0;
    in_bus.valid     = 1'b0;
    in_bus.kind      = KIND_LOAD;
    in_bus.byte_addr = '0;
    in_bus.byte_data = '0;
    in_bus.x_pos     = '0;
    in_bus.y_pos     = '0;
    out_bus.ready    = 1'b0;
    forever #2 clk = ~clk;
  end

  // Driver: record accepted loads in the shadow, expect a tally for each accepted query, then offer the next beat
  always @(posedge clk) begin
    pixel_beat_t nxt;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        if (in_bus.kind == KIND_LOAD) shadow_bitmap[in_bus.byte_addr] = in_bus.byte_data;
        else tallies_due.push_back(window_tally(in_bus.x_pos, in_bus.y_pos));
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (beats_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          nxt = beats_to_send.pop_front();
          in_bus.valid     <= 1'b1;
          in_bus.kind      <= nxt.kind;
          in_bus.byte_addr <= nxt.byte_addr;
          in_bus.byte_data <= nxt.byte_data;
          in_bus.x_pos     <= nxt.x_pos;
          in_bus.y_pos     <= nxt.y_pos;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat against the oldest expected tally
  always @(posedge clk) begin
    window_tally_t want;
    logic          stall_now;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (tallies_due.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got count %0d flag %0b",
                   $time, out_bus.black_count, out_bus.mostly_black);
          mismatch_count++;
        end else begin
          want = tallies_due.pop_front();
          if (out_bus.black_count !== want.black_count) begin
            $display("%0t: black_count mismatch, expected %0d, got %0d",
                     $time, want.black_count, out_bus.black_count);
            mismatch_count++;
          end
          if (out_bus.mostly_black !== want.mostly_black) begin
            $display("%0t: mostly_black mismatch, expected %0b, got %0b",
                     $time, want.mostly_black, out_bus.mostly_black);
            mismatch_count++;
          end
        end
      end
      // Hold off for a long stretch when asked, else stall at random
      stall_now = (holdoff_left != 0) || (holdoff_served != holdoff_requests);
      if (holdoff_left != 0) begin
        holdoff_left <= holdoff_left - 1;
      end else if (holdoff_served != holdoff_requests) begin
        holdoff_left   <= HOLDOFF_CYC;
        holdoff_served <= holdoff_served + 1;
      end
      out_bus.ready <= !stall_now && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic queue_load(input int unsigned addr, input int unsigned data);
    pixel_beat_t b;
    b.kind      = KIND_LOAD;
    b.byte_addr = STORE_ADDR_W'(addr);
    b.byte_data = BYTE_W'(data);
    b.x_pos     = X_W'($urandom);
    b.y_pos     = Y_W'($urandom);
    loaded_bytes[b.byte_addr] = 1'b1;
    beats_to_send.push_back(b);
    items_queued++;
  endtask

  // Load any byte a maximal window from this corner could touch, then query
  task automatic queue_query(input int unsigned cx, input int unsigned cy);
    pixel_beat_t b;
    int unsigned addr, j, k;
    for (j = 0; j < MAX_WIN_DEF; j++) begin
      for (k = 0; k < 2; k++) begin
        addr = ((cy + j) * ROW_BYTES + (cx >> 3) + k) % STORE_DEPTH;
        if (!loaded_bytes[addr]) queue_load(addr, $urandom_range(0, 255));
      end
    end
    b.kind      = KIND_QUERY;
    b.byte_addr = STORE_ADDR_W'($urandom);
    b.byte_data = BYTE_W'($urandom);
    b.x_pos     = X_W'(cx);
    b.y_pos     = Y_W'(cy);
    beats_to_send.push_back(b);
    items_queued++;
  endtask

  // Mostly windows near the top-left and bottom-right corners, some anywhere, some overwrites
  task automatic queue_traffic(input int n);
    int          start;
    int unsigned pick;
    start = items_queued;
    while (items_queued - start < n) begin
      pick = $urandom_range(99);
      if (pick < 8)
        queue_load($urandom_range(0, STORE_DEPTH - 1), $urandom_range(0, 255));
      else if (pick < 20)
        queue_load($urandom_range(0, 23) * ROW_BYTES + $urandom_range(0, 5),
                   $urandom_range(0, 255));
      else if (pick < 50)
        queue_query($urandom_range(0, 31), $urandom_range(0, 15));
      else if (pick < 75)
        queue_query($urandom_range(X_RANGE - 32, X_RANGE - 1),
                    $urandom_range(Y_RANGE - 16, Y_RANGE - 1));
      else
        queue_query($urandom_range(0, X_RANGE - 1), $urandom_range(0, Y_RANGE - 1));
    end
  endtask

  task automatic wait_drained();
    while (beats_to_send.size() != 0 || in_bus.valid || tallies_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Write all three registers on consecutive edges; the block is idle here
  task automatic program_window(input int unsigned w, input int unsigned h,
                                input int unsigned thr);
    @(posedge clk);
    cfg_we         <= 1'b1;
    cfg_index      <= CFG_WIN_WIDTH;
    cfg_wdata      <= CFG_DATA_W'(w);
    win_width_cfg  = WIN_W'(w);
    @(posedge clk);
    cfg_index      <= CFG_WIN_HEIGHT;
    cfg_wdata      <= CFG_DATA_W'(h);
    win_height_cfg = WIN_W'(h);
    @(posedge clk);
    cfg_index      <= CFG_THRESHOLD;
    cfg_wdata      <= CFG_DATA_W'(thr);
    threshold_cfg  = THR_W'(thr);
    @(posedge clk);
    cfg_we         <= 1'b0;
  endtask

  task automatic set_pacing(input pacing_t pace);
    sender_idle_pct = (pace == PACE_SENDER) ? 88 : (pace == PACE_BOTH) ? 13 : 0;
    sink_stall_pct  = (pace == PACE_SINK)   ? 88 : (pace == PACE_BOTH) ? 13 : 0;
  endtask

  task automatic run_phase(input int unsigned w, input int unsigned h, input int unsigned thr,
                           input pacing_t pace, input int n);
    program_window(w, h, thr);
    set_pacing(pace);
    queue_traffic(n);
    wait_drained();
  endtask

  // Stimulus
  initial begin
    int p;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats at reset settings: store extremes, image edges, overwrite
    set_pacing(PACE_NONE);
    queue_load(0, 8'hFF);
    queue_load(STORE_DEPTH - 1, 8'h80);
    queue_load(1, 8'h01);
    queue_query(0, 0);
    queue_query(7, 0);
    queue_query(X_RANGE - 1, Y_RANGE - 1);
    queue_query(X_RANGE - 4, 0);
    queue_query(0, Y_RANGE - 2);
    queue_load(0, 8'h00);
    queue_query(0, 0);
    wait_drained();

    // Extremes of every register under each pacing
    run_phase(8, 8, 32, PACE_NONE, 140);
    run_phase(1, 1, 1, PACE_SENDER, 120);
    run_phase(0, 5, 0, PACE_SINK, 100);
    run_phase(15, 15, 64, PACE_BOTH, 140);
    run_phase(5, 0, 3, PACE_SENDER, 100);
    run_phase(8, 2, 127, PACE_SINK, 120);

    // Back up the result side while the sender keeps offering beats
    program_window(8, 8, 20);
    set_pacing(PACE_NONE);
    holdoff_requests <= holdoff_requests + 1;
    queue_traffic(80);
    wait_drained();
    queue_traffic(80);
    wait_drained();

    // Random settings, cycling through the pacings
    for (p = 0; p < 6; p++)
      run_phase($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 127),
                pacing_t'(p % 4), 120);

    if (mismatch_count == 0 && tallies_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: bitmap_window_majority.f
+incdir+rtl
rtl/bwm_pkg.sv
rtl/bwm_in_if.sv
rtl/bwm_out_if.sv
rtl/bwm_ram.sv
rtl/bitmap_window_majority.sv
tb/bitmap_window_majority_tb.sv
